// File: src/vnos_pkg.sv
`timescale 1ns / 1ps

package vnos_pkg;

  localparam int VNOS_TABLE_SIDE  = 256;
  localparam int VNOS_MAX_OCTAVES = 16;

  localparam int DATA_W  = 16;
  localparam int COORD_W = 24;
  localparam int FRAC_W  = 16;
  localparam int RES_W   = 17;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [15:0] SCALE_RESET = 16'd256;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // octave weight 0.5*(2/3)^k, Q0.16
  function automatic logic [15:0] octave_weight(input logic [3:0] k);
    logic [15:0] w;
    case (k)
      4'd0:    w = 16'd32768;
      4'd1:    w = 16'd21845;
      4'd2:    w = 16'd14564;
      4'd3:    w = 16'd9709;
      4'd4:    w = 16'd6473;
      4'd5:    w = 16'd4315;
      4'd6:    w = 16'd2877;
      4'd7:    w = 16'd1918;
      4'd8:    w = 16'd1279;
      4'd9:    w = 16'd852;
      4'd10:   w = 16'd568;
      4'd11:   w = 16'd379;
      4'd12:   w = 16'd253;
      4'd13:   w = 16'd168;
      4'd14:   w = 16'd112;
      default: w = 16'd75;
    endcase
    return w;
  endfunction

endpackage

// File: src/vnos_mul.sv
`timescale 1ns / 1ps

module vnos_mul (
  input  logic                                clk,
  input  logic signed [vnos_pkg::MUL_A_W-1:0] a,
  input  logic signed [vnos_pkg::MUL_B_W-1:0] b,
  output logic signed [vnos_pkg::MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: src/vnos_table.sv
`timescale 1ns / 1ps

module vnos_table #(
  parameter int AW = 16
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     addr,
  input  logic [vnos_pkg::DATA_W-1:0]       wdata,
  output logic [vnos_pkg::DATA_W-1:0]       rdata
);

  logic [vnos_pkg::DATA_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/value_noise_octave_sampler.sv
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// cfg      | cfg_valid / cfg_ready  | start_scale
// in       | in_valid / in_ready    | action, table_index, table_value, x_coord, y_coord
// out      | out_valid / out_ready  | noise_value
//
// A sample beat loops over N octaves before its result is ready, N = octaves run
// (scale doubles from start_scale until it reaches 1.0, at most MAX_OCTAVES).
// Each octave is paced by one shared multiplier and one table port (four reads).
// Reset (rst, synchronous) clears control and sets start_scale to 256; table
// contents are undefined until written. The result waits in an output register;
// a finished sample holds the sequencer only while that register is still full.

module value_noise_octave_sampler #(
  parameter int TABLE_SIDE  = vnos_pkg::VNOS_TABLE_SIDE,
  parameter int MAX_OCTAVES = vnos_pkg::VNOS_MAX_OCTAVES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [15:0]                          start_scale,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [15:0]                          table_index,
  input  logic signed [vnos_pkg::DATA_W-1:0]   table_value,
  input  logic [vnos_pkg::COORD_W-1:0]         x_coord,
  input  logic [vnos_pkg::COORD_W-1:0]         y_coord,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vnos_pkg::RES_W-1:0]    noise_value
);

  localparam int SW    = $clog2(TABLE_SIDE);
  localparam int AW    = 2 * SW;
  localparam int CELLS = TABLE_SIDE * TABLE_SIDE;
  localparam int KW    = $clog2(MAX_OCTAVES + 1);
  localparam int AW_M  = vnos_pkg::MUL_A_W;
  localparam int BW_M  = vnos_pkg::MUL_B_W;
  localparam int PW_M  = vnos_pkg::MUL_P_W;

  localparam logic [20:0] POS_LIMIT = 21'd65535;
  localparam logic [20:0] NEG_LIMIT = 21'd65536;
  localparam logic [16:0] POS_SAT   = 17'h0FFFF;
  localparam logic [16:0] NEG_SAT   = 17'h10000;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_PX   = 15'b000000000000010,
    S_PY   = 15'b000000000000100,
    S_RA   = 15'b000000000001000,
    S_RB   = 15'b000000000010000,
    S_RC   = 15'b000000000100000,
    S_RD   = 15'b000000001000000,
    S_DIF  = 15'b000000010000000,
    S_MIX  = 15'b000000100000000,
    S_BLD  = 15'b000001000000000,
    S_OCT  = 15'b000010000000000,
    S_WGT  = 15'b000100000000000,
    S_ACC  = 15'b001000000000000,
    S_RND  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [15:0]         scale_cfg;
  logic [16:0]         scale;
  logic [KW-1:0]       k;
  logic [23:0]         x_q, y_q;
  logic [SW-1:0]       c0, r0, c1, r1;
  logic [15:0]         fx, fy;
  logic signed [15:0]  a_s, b_s, c_s;
  logic signed [33:0]  top_v;
  logic signed [34:0]  diff;
  logic signed [33:0]  oct;
  logic signed [52:0]  sum;
  logic [52:0]         mag;
  logic [20:0]         mag_q;
  logic                neg_q;
  logic                res_valid;
  logic [16:0]         res;
  logic [16:0]         res_sat;

  logic signed [AW_M-1:0] mul_a;
  logic signed [BW_M-1:0] mul_b;
  logic signed [PW_M-1:0] prod_q;

  logic                 tbl_we;
  logic [AW-1:0]        tbl_addr;
  logic [15:0]          rd_data;
  logic                 in_range;
  logic                 in_beat;
  logic                 out_free;
  logic                 k_more;
  logic signed [16:0]   dba, dca;
  logic signed [17:0]   ddx;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign in_beat     = in_valid && in_ready;
  assign out_valid   = res_valid;
  assign noise_value = res;
  assign out_free    = !res_valid || out_ready;
  assign in_range    = {16'b0, table_index} < 32'(CELLS);
  assign tbl_we      = in_beat && (action == vnos_pkg::ACT_WRITE) && in_range;
  assign k_more      = (k < KW'(MAX_OCTAVES)) && !scale[16];
  assign c1          = c0 + SW'(1);
  assign r1          = r0 + SW'(1);
  assign dba         = 17'(b_s) - 17'(a_s);
  assign dca         = 17'(c_s) - 17'(a_s);
  assign ddx         = 18'($signed(rd_data)) - 18'(c_s) - 18'(b_s) + 18'(a_s);
  assign mag         = sum[52] ? -sum : sum;

  vnos_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod_q)
  );

  vnos_table #(
    .AW (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (table_value),
    .rdata (rd_data)
  );

  always_comb begin
    case (state)
      S_RA:    tbl_addr = {prod_q[24 +: SW], c0};
      S_RB:    tbl_addr = {r0, c1};
      S_RC:    tbl_addr = {r1, c0};
      S_RD:    tbl_addr = {r1, c1};
      default: tbl_addr = AW'(table_index);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PX, S_ACC: begin
        mul_a = AW_M'(x_q);
        mul_b = BW_M'(scale[15:0]);
      end
      S_PY: begin
        mul_a = AW_M'(y_q);
        mul_b = BW_M'(scale[15:0]);
      end
      S_RD: begin
        mul_a = AW_M'(dba);
        mul_b = BW_M'(fx);
      end
      S_DIF: begin
        mul_a = AW_M'(ddx);
        mul_b = BW_M'(fx);
      end
      S_BLD: begin
        mul_a = diff;
        mul_b = BW_M'(fy);
      end
      S_WGT: begin
        mul_a = AW_M'(oct);
        mul_b = BW_M'(vnos_pkg::octave_weight(4'(k)));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE:  state_next = (in_valid && action == vnos_pkg::ACT_SAMPLE) ? S_PX : S_IDLE;
      S_PX:    state_next = S_PY;
      S_PY:    state_next = S_RA;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = S_RC;
      S_RC:    state_next = S_RD;
      S_RD:    state_next = S_DIF;
      S_DIF:   state_next = S_MIX;
      S_MIX:   state_next = S_BLD;
      S_BLD:   state_next = S_OCT;
      S_OCT:   state_next = S_WGT;
      S_WGT:   state_next = S_ACC;
      S_ACC:   state_next = k_more ? S_PY : S_RND;
      S_RND:   state_next = S_OUT;
      S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (neg_q) begin
      res_sat = (mag_q > NEG_LIMIT) ? NEG_SAT : 17'(21'd0 - mag_q);
    end else begin
      res_sat = (mag_q > POS_LIMIT) ? POS_SAT : mag_q[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scale_cfg <= vnos_pkg::SCALE_RESET;
      scale     <= '0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        scale_cfg <= start_scale;
      end
      if (state == S_IDLE && in_valid) begin
        scale <= {1'b0, scale_cfg};
        k     <= '0;
      end else if (state == S_WGT) begin
        scale <= {scale[15:0], 1'b0};
        k     <= k + KW'(1);
      end
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x_q <= x_coord;
        y_q <= y_coord;
        sum <= '0;
      end
      S_PY: begin
        c0 <= prod_q[24 +: SW];
        fx <= prod_q[23:8];
      end
      S_RA: begin
        r0 <= prod_q[24 +: SW];
        fy <= prod_q[23:8];
      end
      S_RB:  a_s <= rd_data;
      S_RC:  b_s <= rd_data;
      S_RD:  c_s <= rd_data;
      S_DIF: top_v <= {{2{a_s[15]}}, a_s, 16'b0} + prod_q[33:0];
      S_MIX: diff <= {dca[16], dca[16], dca, 16'b0} + prod_q[34:0];
      S_OCT: oct <= top_v + $signed(prod_q[49:16]);
      S_ACC: sum <= sum + prod_q;
      S_RND: begin
        neg_q <= sum[52];
        mag_q <= mag[52:32];
      end
      S_OUT: begin
        if (out_free) begin
          res <= res_sat;
        end
      end
      default: begin
      end
    endcase
  end

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    k <= KW'(MAX_OCTAVES))
    else $error("octave count past limit");

  a_loop_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && state_next == S_RND) |-> (k >= KW'(MAX_OCTAVES) || scale[16]))
    else $error("octave loop left early");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_beat && action == vnos_pkg::ACT_WRITE) |=> (state == S_IDLE))
    else $error("write beat started a sample");

  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_IDLE))
    else $error("table write outside idle");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded");

endmodule

// File: tb/value_noise_octave_sampler_tb.sv
`timescale 1ns / 1ps

module value_noise_octave_sampler_tb;

  localparam int TABLE_CELLS     = vnos_pkg::VNOS_TABLE_SIDE * vnos_pkg::VNOS_TABLE_SIDE;
  localparam int SETTLE_CYCLES   = 11 * vnos_pkg::VNOS_MAX_OCTAVES + 3 + 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1500000;
  localparam int PHASES          = 9;
  localparam int BEATS_PER_PHASE = 85;
  localparam int LOAD_SPAN       = 10;

  class noise_scoreboard;
    logic signed [15:0] cells [TABLE_CELLS];
    longint             weight_q16 [vnos_pkg::VNOS_MAX_OCTAVES];
    logic [15:0]        scale;
    logic signed [16:0] expected_noise [$];
    int                 errors;

    function new();
      real w;
      scale  = vnos_pkg::SCALE_RESET;
      errors = 0;
      w = 0.5;
      for (int k = 0; k < vnos_pkg::VNOS_MAX_OCTAVES; k++) begin
        weight_q16[k] = longint'($rtoi(w * 65536.0 + 0.5));
        w = w * 2.0 / 3.0;
      end
    endfunction

    function longint octave_blend(logic [23:0] x, logic [23:0] y, longint sc);
      longint px, py, fx, fy, a, b, c, d, top, bot;
      int c0, c1, r0, r1, m;
      m  = vnos_pkg::VNOS_TABLE_SIDE - 1;
      px = longint'(x) * sc;
      py = longint'(y) * sc;
      c0 = int'((px >> 24) & m);
      r0 = int'((py >> 24) & m);
      c1 = (c0 + 1) & m;
      r1 = (r0 + 1) & m;
      fx = (px >> 8) & 64'hFFFF;
      fy = (py >> 8) & 64'hFFFF;
      a = cells[r0 * vnos_pkg::VNOS_TABLE_SIDE + c0];
      b = cells[r0 * vnos_pkg::VNOS_TABLE_SIDE + c1];
      c = cells[r1 * vnos_pkg::VNOS_TABLE_SIDE + c0];
      d = cells[r1 * vnos_pkg::VNOS_TABLE_SIDE + c1];
      top = a * (65536 - fx) + b * fx;
      bot = c * (65536 - fx) + d * fx;
      return (top * (65536 - fy) + bot * fy) >>> 16;
    endfunction

    function logic signed [16:0] sample_noise(logic [23:0] x, logic [23:0] y);
      longint acc, sc, r;
      int k;
      acc = 0;
      sc  = longint'(scale);
      for (k = 0; k < vnos_pkg::VNOS_MAX_OCTAVES && sc < 65536; k++) begin
        acc += octave_blend(x, y, sc) * weight_q16[k];
        sc = sc << 1;
      end
      if (acc >= 0) r = acc >>> 32;
      else r = -((-acc) >>> 32);
      if (r > 65535) r = 65535;
      if (r < -65536) r = -65536;
      return r[16:0];
    endfunction

    function void note_beat(logic act, logic [15:0] idx, logic signed [15:0] val,
                            logic [23:0] x, logic [23:0] y);
      if (act == vnos_pkg::ACT_WRITE) begin
        if (int'(idx) < TABLE_CELLS) cells[idx] = val;
      end else begin
        expected_noise.push_back(sample_noise(x, y));
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_noise(logic signed [16:0] got);
      logic signed [16:0] want;
      if (expected_noise.size() == 0) begin
        report($sformatf("noise_value %0d with no sample pending", got));
      end else begin
        want = expected_noise.pop_front();
        if (got !== want) report($sformatf("noise_value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        start_scale = vnos_pkg::SCALE_RESET;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = vnos_pkg::ACT_WRITE;
  logic [15:0]        table_index = '0;
  logic signed [15:0] table_value = '0;
  logic [23:0]        x_coord = '0;
  logic [23:0]        y_coord = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] noise_value;

  noise_scoreboard noise_sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;
  int          writes_seen = 0;
  int          samples_seen = 0;
  int          results_seen = 0;
  int          scales_run = 0;

  value_noise_octave_sampler u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .start_scale (start_scale),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .table_index (table_index),
    .table_value (table_value),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) noise_sb.scale = start_scale;
      if (in_valid && in_ready) begin
        noise_sb.note_beat(action, table_index, table_value, x_coord, y_coord);
        if (action == vnos_pkg::ACT_SAMPLE) samples_seen++;
        else writes_seen++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        noise_sb.check_noise(noise_value);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(logic act, logic [15:0] idx, logic [15:0] val,
                           logic [23:0] x, logic [23:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    table_index <= idx;
    table_value <= val;
    x_coord     <= x;
    y_coord     <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // keep sample points below 8.0 so every read lands in the loaded corner
  task automatic random_beat(bit sample_only);
    logic [31:0] r;
    logic [15:0] idx, val;
    logic [23:0] x, y;
    logic        act;
    act = (!sample_only && $urandom_range(9) < 3) ? vnos_pkg::ACT_WRITE : vnos_pkg::ACT_SAMPLE;
    r = $urandom; idx = r[15:0]; val = r[31:16];
    r = $urandom; x = {13'b0, r[10:0]};
    r = $urandom; y = {13'b0, r[10:0]};
    case ($urandom_range(9))
      0: val = 16'h8000;
      1: val = 16'h7FFF;
      default: ;
    endcase
    case ($urandom_range(15))
      0: x = '0;
      1: x = 24'h0007FF;
      2: x[7:0] = '0;
      default: ;
    endcase
    case ($urandom_range(15))
      0: y = '0;
      1: y = 24'h0007FF;
      2: y[7:0] = '1;
      default: ;
    endcase
    send_beat(act, idx, val, x, y);
  endtask

  // load rows and columns 255 and 0..8, the entries that all samples here reach
  task automatic load_table();
    logic [31:0] r;
    logic [15:0] val;
    int row, col;
    for (int i = 0; i < LOAD_SPAN * LOAD_SPAN; i++) begin
      row = (i / LOAD_SPAN + vnos_pkg::VNOS_TABLE_SIDE - 1) % vnos_pkg::VNOS_TABLE_SIDE;
      col = (i % LOAD_SPAN + vnos_pkg::VNOS_TABLE_SIDE - 1) % vnos_pkg::VNOS_TABLE_SIDE;
      r = $urandom;
      val = r[15:0];
      if (r[31:28] == 4'h0) val = 16'h8000;
      if (r[31:28] == 4'h1) val = 16'h7FFF;
      send_beat(vnos_pkg::ACT_WRITE, 16'(row * vnos_pkg::VNOS_TABLE_SIDE + col), val,
                r[23:0], r[27:4]);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (noise_sb.expected_noise.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    wait_idle();
    cfg_valid   <= 1'b1;
    start_scale <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_beats();
    send_beat(vnos_pkg::ACT_WRITE, 16'd0, 16'h8000, '0, '0);
    send_beat(vnos_pkg::ACT_WRITE, 16'd1, 16'h8000, '1, '1);
    send_beat(vnos_pkg::ACT_WRITE, 16'd256, 16'h8000, '0, '0);
    send_beat(vnos_pkg::ACT_WRITE, 16'd257, 16'h8000, '0, '0);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h000000, 24'h000000);
    send_beat(vnos_pkg::ACT_WRITE, 16'hFFFF, 16'h7FFF, '0, '0);
    send_beat(vnos_pkg::ACT_WRITE, 16'hFF00, 16'h7FFF, '0, '0);
    send_beat(vnos_pkg::ACT_WRITE, 16'h00FF, 16'h7FFF, '0, '0);
    send_beat(vnos_pkg::ACT_SAMPLE, '1, '1, 24'hFFFFFF, 24'hFFFFFF);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'hFFFFFF, 24'h000000);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h000000, 24'hFFFFFF);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h000080, 24'h000080);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'hFFFF00, 24'h0000FF);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h000400, 24'h0007FF);
    send_beat(vnos_pkg::ACT_WRITE, 16'h0000, 16'h0000, '0, '0);
    send_beat(vnos_pkg::ACT_WRITE, 16'h5A5A, 16'h1234, '0, '0);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h000001, 24'hFFFFFE);
    send_beat(vnos_pkg::ACT_SAMPLE, '0, '0, 24'h0005A5, 24'h0005A5);
  endtask

  initial begin
    logic [15:0] scale_plan [PHASES];
    logic [31:0] r;
    noise_sb = new();
    scale_plan = '{16'd256, 16'd1, 16'hFFFF, 16'd0, 16'h8000, 16'd0, 16'd128, 16'd0, 16'd4096};
    r = $urandom_range(65535, 1);
    scale_plan[5] = r[15:0];
    r = $urandom_range(65535, 1);
    scale_plan[7] = r[15:0];

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 47;
    @(negedge clk);
    load_table();
    directed_beats();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 23; recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph != 0) write_scale(scale_plan[ph]);
      scales_run++;
      if (ph == 6) begin
        // stall the result side and keep feeding samples until input backs up
        hold_requests++;
        repeat (24) random_beat(1'b1);
        in_valid <= 1'b0;
        do @(negedge clk); while (noise_sb.expected_noise.size() != 0);
      end
      repeat (BEATS_PER_PHASE) random_beat(1'b0);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (noise_sb.expected_noise.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run: %0d table writes incl. table load, %0d noise samples, %0d start scales",
             writes_seen, samples_seen, scales_run);
    $display("checked %0d noise results across scales 0, 1, 65535 and others; %0d mismatches",
             results_seen, noise_sb.errors);
    if (noise_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/vnos_pkg.sv
src/vnos_mul.sv
src/vnos_table.sv
src/value_noise_octave_sampler.sv
tb/value_noise_octave_sampler_tb.sv
